// ===== design/dkms_pkg.sv =====
// ----------------------------------------------------------------------------
// dkms_pkg: shared types for the duplex key matrix scanner
// Item and result structs, configuration struct, memory request bundle,
// sequencer states and the column search helper.
// ----------------------------------------------------------------------------
package dkms_pkg;

    localparam int ROWS_DEF       = 8;
    localparam int PHYS_COLS_DEF  = 8;
    localparam int LINE_W         = 4;
    localparam int ROW_BITS_W     = 16;
    localparam int PADDR_W        = 4;

    localparam logic [9:0] SETTLE_RST      = 10'd30;
    localparam logic [7:0] ROW_PRESENT_RST = 8'hFF;
    localparam logic [7:0] COL_PRESENT_RST = 8'hFF;

    localparam logic [1:0] REG_SETTLE      = 2'd0;
    localparam logic [1:0] REG_ROW_PRESENT = 2'd1;
    localparam logic [1:0] REG_COL_PRESENT = 2'd2;

    typedef struct packed {
        logic [7:0] col_levels;
        logic [7:0] row_levels;
        logic [2:0] read_row;
    } tick_t;

    typedef struct packed {
        logic [7:0]            row_drive;
        logic [7:0]            col_drive;
        logic                  scan_done;
        logic                  matrix_changed;
        logic [ROW_BITS_W-1:0] row_bits;
    } res_t;

    typedef struct packed {
        logic [9:0] settle_ticks;
        logic [7:0] row_present;
        logic [7:0] col_present;
    } cfg_t;

    typedef struct packed {
        logic                  scr_rd_en;
        logic [LINE_W-1:0]     scr_rd_addr;
        logic                  scr_wr_en;
        logic [LINE_W-1:0]     scr_wr_addr;
        logic [ROW_BITS_W-1:0] scr_wr_data;
        logic                  key_rd_en;
        logic [LINE_W-1:0]     key_rd_addr;
        logic                  key_wr_en;
        logic [LINE_W-1:0]     key_wr_addr;
        logic [ROW_BITS_W-1:0] key_wr_data;
    } mem_req_t;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } col_pick_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLWALK,
        ST_ENDWALK,
        ST_READ,
        ST_RESULT
    } state_t;

    function automatic logic bit_at(input logic [7:0] mask, input logic [LINE_W-1:0] idx);
        logic hit;
        hit = 1'b0;
        if (idx < LINE_W'(8))
        begin
            hit = mask[idx[2:0]];
        end
        return hit;
    endfunction

    function automatic col_pick_t first_col(input logic [7:0] mask, input logic [LINE_W-1:0] from);
        col_pick_t pick;
        pick = '0;
        for (int c = 7; c >= 0; c--)
        begin
            if (mask[c] && (LINE_W'(c) >= from))
            begin
                pick.found = 1'b1;
                pick.idx   = 3'(c);
            end
        end
        return pick;
    endfunction

endpackage

// ===== design/dkms_regs.sv =====
// ----------------------------------------------------------------------------
// dkms_regs: configuration register file
// APB-style write and read of settle time and row and column present masks.
// ----------------------------------------------------------------------------
module dkms_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dkms_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dkms_pkg::cfg_t                cfg
);

    dkms_pkg::cfg_t cfg_reg;
    dkms_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                dkms_pkg::REG_SETTLE:      cfg_next.settle_ticks = pwdata[9:0];
                dkms_pkg::REG_ROW_PRESENT: cfg_next.row_present  = pwdata[7:0];
                dkms_pkg::REG_COL_PRESENT: cfg_next.col_present  = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            dkms_pkg::REG_SETTLE:      prdata = {22'd0, cfg_reg.settle_ticks};
            dkms_pkg::REG_ROW_PRESENT: prdata = {24'd0, cfg_reg.row_present};
            dkms_pkg::REG_COL_PRESENT: prdata = {24'd0, cfg_reg.col_present};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks <= dkms_pkg::SETTLE_RST;
            cfg_reg.row_present  <= dkms_pkg::ROW_PRESENT_RST;
            cfg_reg.col_present  <= dkms_pkg::COL_PRESENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/dkms_store.sv =====
// ----------------------------------------------------------------------------
// dkms_store: scratch row memory and key matrix memory
// Two single-port-write, registered-read memories; key rows read as zero
// until first written.
// ----------------------------------------------------------------------------
module dkms_store
#(
    parameter int ROWS = dkms_pkg::ROWS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dkms_pkg::mem_req_t                  req,
    output logic [dkms_pkg::ROW_BITS_W-1:0]     scr_rdata,
    output logic [dkms_pkg::ROW_BITS_W-1:0]     key_rdata
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [dkms_pkg::ROW_BITS_W-1:0] scr_mem [ROWS];
    logic [dkms_pkg::ROW_BITS_W-1:0] key_mem [ROWS];
    logic [dkms_pkg::ROW_BITS_W-1:0] scr_rdata_reg;
    logic [dkms_pkg::ROW_BITS_W-1:0] key_rdata_reg;
    logic [ROWS-1:0]                 key_vld_reg;
    logic                            key_rvld_reg;

    always_ff @(posedge clk)
    begin
        if (req.scr_wr_en)
        begin
            scr_mem[req.scr_wr_addr[ROW_W-1:0]] <= req.scr_wr_data;
        end
        if (req.scr_rd_en)
        begin
            scr_rdata_reg <= scr_mem[req.scr_rd_addr[ROW_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.key_wr_en)
        begin
            key_mem[req.key_wr_addr[ROW_W-1:0]] <= req.key_wr_data;
        end
        if (req.key_rd_en)
        begin
            key_rdata_reg <= key_mem[req.key_rd_addr[ROW_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg  <= '0;
            key_rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.key_wr_en)
            begin
                key_vld_reg[req.key_wr_addr[ROW_W-1:0]] <= 1'b1;
            end
            if (req.key_rd_en)
            begin
                key_rvld_reg <= key_vld_reg[req.key_rd_addr[ROW_W-1:0]];
            end
        end
    end

    assign scr_rdata = scr_rdata_reg;
    assign key_rdata = key_rvld_reg ? key_rdata_reg : '0;

endmodule

// ===== design/dkms_ctrl.sv =====
// ----------------------------------------------------------------------------
// dkms_ctrl: scan sequencer
// Times each line, samples pins, walks the scratch rows for the column pass
// and the end-of-scan copy, and builds the result item.
// ----------------------------------------------------------------------------
module dkms_ctrl
#(
    parameter int ROWS           = dkms_pkg::ROWS_DEF,
    parameter int PHYS_COL_COUNT = dkms_pkg::PHYS_COLS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dkms_pkg::cfg_t                   cfg,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  dkms_pkg::tick_t                  tick,
    output logic                             res_valid,
    input  logic                             res_ready,
    output dkms_pkg::res_t                   res,
    output dkms_pkg::mem_req_t               req,
    input  logic [dkms_pkg::ROW_BITS_W-1:0]  scr_rdata,
    input  logic [dkms_pkg::ROW_BITS_W-1:0]  key_rdata
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int LW     = dkms_pkg::LINE_W;
    localparam logic [7:0] PHYS_MASK = 8'((16'd1 << PHYS_COL_COUNT) - 16'd1);

    dkms_pkg::state_t    state_reg, state_next;
    logic                pass_reg, pass_next;
    logic [LW-1:0]       line_reg, line_next;
    logic [9:0]          settle_reg, settle_next;
    logic [7:0]          rows_reg, rows_next;
    logic [2:0]          rd_reg, rd_next;
    logic [2:0]          col_reg, col_next;
    logic                end_reg, end_next;
    logic                done_reg, done_next;
    logic                chg_reg, chg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                wb_vld_reg, wb_vld_next;
    logic [ROW_W-1:0]    wb_idx_reg, wb_idx_next;
    logic                res_valid_reg, res_valid_next;
    dkms_pkg::res_t      res_reg, res_next;

    logic                accept;
    logic                sample;
    logic [7:0]          col_mask;
    dkms_pkg::col_pick_t pick_first;
    dkms_pkg::col_pick_t pick_next;
    logic                row_last;
    logic                col_here;
    logic                end_scan;
    logic                walking;
    logic                walk_issue;
    logic                walk_last;
    logic                rd_in_range;
    logic                res_load;
    logic                hit;

    assign accept      = tick_valid && tick_ready;
    assign tick_ready  = (state_reg == dkms_pkg::ST_IDLE);
    assign sample      = ({1'b0, settle_reg} + 11'd1) >= {1'b0, cfg.settle_ticks};
    assign col_mask    = cfg.col_present & PHYS_MASK;
    assign pick_first  = dkms_pkg::first_col(col_mask, '0);
    assign pick_next   = dkms_pkg::first_col(col_mask, line_reg + LW'(1));
    assign row_last    = ({1'b0, line_reg} + 5'd1) >= 5'(ROWS);
    assign col_here    = dkms_pkg::bit_at(col_mask, line_reg);
    assign end_scan    = pass_reg ? !pick_next.found : (row_last && !pick_first.found);
    assign walking     = (state_reg == dkms_pkg::ST_COLWALK) || (state_reg == dkms_pkg::ST_ENDWALK);
    assign walk_issue  = walking && (cnt_reg < CNT_W'(ROWS));
    assign walk_last   = walking && (cnt_reg == CNT_W'(ROWS));
    assign rd_in_range = {2'b00, rd_reg} < 5'(ROWS);
    assign res_load    = (state_reg == dkms_pkg::ST_RESULT) && (!res_valid_reg || res_ready);
    assign hit         = dkms_pkg::bit_at(cfg.row_present & ~rows_reg, LW'(wb_idx_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dkms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!sample)
                    begin
                        state_next = dkms_pkg::ST_READ;
                    end
                    else if (pass_reg && col_here)
                    begin
                        state_next = dkms_pkg::ST_COLWALK;
                    end
                    else if (end_scan)
                    begin
                        state_next = dkms_pkg::ST_ENDWALK;
                    end
                    else
                    begin
                        state_next = dkms_pkg::ST_READ;
                    end
                end
            end
            dkms_pkg::ST_COLWALK:
            begin
                if (walk_last)
                begin
                    state_next = end_reg ? dkms_pkg::ST_ENDWALK : dkms_pkg::ST_READ;
                end
            end
            dkms_pkg::ST_ENDWALK:
            begin
                if (walk_last)
                begin
                    state_next = dkms_pkg::ST_READ;
                end
            end
            dkms_pkg::ST_READ:   state_next = dkms_pkg::ST_RESULT;
            dkms_pkg::ST_RESULT:
            begin
                if (res_load)
                begin
                    state_next = dkms_pkg::ST_IDLE;
                end
            end
            default:             state_next = dkms_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pass_next   = pass_reg;
        line_next   = line_reg;
        settle_next = settle_reg;
        rows_next   = rows_reg;
        rd_next     = rd_reg;
        col_next    = col_reg;
        end_next    = end_reg;
        done_next   = done_reg;
        chg_next    = chg_reg;
        cnt_next    = '0;
        wb_vld_next = 1'b0;
        wb_idx_next = wb_idx_reg;

        if (accept)
        begin
            rows_next = tick.row_levels;
            rd_next   = tick.read_row;
            done_next = 1'b0;
            chg_next  = 1'b0;
            end_next  = 1'b0;
            if (!sample)
            begin
                settle_next = settle_reg + 10'd1;
            end
            else
            begin
                settle_next = '0;
                end_next    = end_scan;
                done_next   = end_scan;
                if (!pass_reg)
                begin
                    line_next = line_reg + LW'(1);
                    if (row_last && pick_first.found)
                    begin
                        pass_next = 1'b1;
                        line_next = LW'(pick_first.idx);
                    end
                end
                else
                begin
                    col_next  = line_reg[2:0];
                    line_next = LW'(pick_next.idx);
                end
                if (end_scan)
                begin
                    pass_next = 1'b0;
                    line_next = '0;
                end
            end
        end

        if (walking)
        begin
            cnt_next    = walk_issue ? cnt_reg + CNT_W'(1) : '0;
            wb_vld_next = walk_issue;
            wb_idx_next = cnt_reg[ROW_W-1:0];
        end

        if ((state_reg == dkms_pkg::ST_ENDWALK) && wb_vld_reg && (key_rdata != scr_rdata))
        begin
            chg_next = 1'b1;
        end
    end

    always_comb
    begin
        req = '0;
        case (state_reg)
            dkms_pkg::ST_IDLE:
            begin
                req.scr_wr_en   = accept && sample && !pass_reg;
                req.scr_wr_addr = line_reg;
                req.scr_wr_data = {8'd0, ~tick.col_levels & col_mask};
            end
            dkms_pkg::ST_COLWALK:
            begin
                req.scr_rd_en   = walk_issue;
                req.scr_rd_addr = LW'(cnt_reg);
                req.scr_wr_en   = wb_vld_reg;
                req.scr_wr_addr = LW'(wb_idx_reg);
                req.scr_wr_data = scr_rdata
                                | (hit ? 16'(16'd1 << (5'd8 + {2'b00, col_reg})) : 16'd0);
            end
            dkms_pkg::ST_ENDWALK:
            begin
                req.scr_rd_en   = walk_issue;
                req.scr_rd_addr = LW'(cnt_reg);
                req.key_rd_en   = walk_issue;
                req.key_rd_addr = LW'(cnt_reg);
                req.key_wr_en   = wb_vld_reg;
                req.key_wr_addr = LW'(wb_idx_reg);
                req.key_wr_data = scr_rdata;
            end
            dkms_pkg::ST_READ:
            begin
                req.key_rd_en   = 1'b1;
                req.key_rd_addr = rd_in_range ? LW'(rd_reg) : '0;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next         = 1'b1;
            res_next.row_drive     = (!pass_reg && dkms_pkg::bit_at(cfg.row_present, line_reg))
                                     ? 8'(8'd1 << line_reg[2:0]) : 8'd0;
            res_next.col_drive     = (pass_reg && dkms_pkg::bit_at(col_mask, line_reg))
                                     ? 8'(8'd1 << line_reg[2:0]) : 8'd0;
            res_next.scan_done     = done_reg;
            res_next.matrix_changed = done_reg && chg_reg;
            res_next.row_bits      = rd_in_range ? key_rdata : '0;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dkms_pkg::ST_IDLE;
            pass_reg      <= 1'b0;
            line_reg      <= '0;
            settle_reg    <= '0;
            end_reg       <= 1'b0;
            done_reg      <= 1'b0;
            chg_reg       <= 1'b0;
            cnt_reg       <= '0;
            wb_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            line_reg      <= line_next;
            settle_reg    <= settle_next;
            end_reg       <= end_next;
            done_reg      <= done_next;
            chg_reg       <= chg_next;
            cnt_reg       <= cnt_next;
            wb_vld_reg    <= wb_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg   <= rows_next;
        rd_reg     <= rd_next;
        col_reg    <= col_next;
        wb_idx_reg <= wb_idx_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/duplex_key_matrix_scanner.sv =====
// ----------------------------------------------------------------------------
// duplex_key_matrix_scanner: diode-less duplex key matrix scanner
// Each tick item carries sampled pin levels; each result item carries the
// next drive masks, scan flags and one key matrix row.
//
// Usage:
//   tick channel (tick_valid/tick_ready/tick): one item per scan tick with
//   the column and row pin levels seen during that tick and a row index.
//   res channel (res_valid/res_ready/res): exactly one item per tick item,
//   with the drive for the next tick and key matrix row read_row after it.
//   APB port: settle_ticks at 0x0, row_present at 0x4, col_present at 0x8.
// Sequencing: one item at a time. A tick that only counts settle time
//   passes through the read and result states; a column sample adds a
//   read-modify-write walk over the scratch memory; the end of a scan adds
//   a compare and copy walk into the key matrix memory.
// Reset: registers take their defaults, the scan restarts at row 0 and the
//   key matrix reads as zero; no clearing pass is needed.
// Stall: a result waits in the output register while the next tick is
//   accepted; the following result holds until res_ready frees it.
// ----------------------------------------------------------------------------
module duplex_key_matrix_scanner
#(
    parameter int ROWS           = dkms_pkg::ROWS_DEF,
    parameter int PHYS_COL_COUNT = dkms_pkg::PHYS_COLS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_valid,
    output logic                         tick_ready,
    input  dkms_pkg::tick_t              tick,
    output logic                         res_valid,
    input  logic                         res_ready,
    output dkms_pkg::res_t               res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dkms_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    dkms_pkg::cfg_t                  cfg;
    dkms_pkg::mem_req_t              req;
    logic [dkms_pkg::ROW_BITS_W-1:0] scr_rdata;
    logic [dkms_pkg::ROW_BITS_W-1:0] key_rdata;

    dkms_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dkms_store
    #(
        .ROWS (ROWS)
    )
    u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .scr_rdata (scr_rdata),
        .key_rdata (key_rdata)
    );

    dkms_ctrl
    #(
        .ROWS           (ROWS),
        .PHYS_COL_COUNT (PHYS_COL_COUNT)
    )
    u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .req        (req),
        .scr_rdata  (scr_rdata),
        .key_rdata  (key_rdata)
    );

endmodule

// ===== design/dkms_checker.sv =====
// ----------------------------------------------------------------------------
// dkms_checker: port-level checks for the duplex key matrix scanner
// Watches the tick and result channels of the top level.
// ----------------------------------------------------------------------------
module dkms_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick_valid,
    input  logic           tick_ready,
    input  logic           res_valid,
    input  dkms_pkg::res_t res
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> !tick_ready)
        else $error("tick accepted on back-to-back cycles");

    a_changed_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.matrix_changed || res.scan_done))
        else $error("matrix_changed without scan_done");

    a_row_drive_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0(res.row_drive))
        else $error("more than one row driven");

    a_col_drive_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0(res.col_drive))
        else $error("more than one column driven");

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.row_drive == 8'd0) || (res.col_drive == 8'd0)))
        else $error("row and column driven together");

endmodule

bind duplex_key_matrix_scanner dkms_checker u_dkms_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .res_valid  (res_valid),
    .res        (res)
);
